// ===== hw/rtl/swerve_drive_module_commander_defines.svh =====
// Assertion macros for the swerve drive module commander.
`ifndef SWERVE_DRIVE_MODULE_COMMANDER_DEFINES_SVH
`define SWERVE_DRIVE_MODULE_COMMANDER_DEFINES_SVH

// Same-cycle implication.
`define SDMC_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdmc assertion failed");

// Next-cycle implication.
`define SDMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdmc assertion failed");

`endif

// ===== hw/rtl/sdmc_pkg.sv =====
// Shared types, constants and tables of the swerve drive module commander.
package sdmc_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int STEP_W = 5;
   localparam int VW = 36;
   localparam int PW = 68;
   localparam int DVW = 44;
   localparam int QW = 15;
   localparam int DIV_STEPS = 15;

   localparam logic signed [31:0] INV_GAIN = 32'sd652032874;
   localparam logic [16:0] ROT_IDLE_LIMIT = 17'd3277;
   localparam logic signed [16:0] QUARTER_TURN = 17'sd16384;
   localparam logic signed [16:0] HALF_TURN = 17'sd32768;

   localparam logic [14:0] DEADBAND_RST = 15'd1638;
   localparam logic [14:0] GAIN_ACROSS_RST = 15'd16384;
   localparam logic [14:0] GAIN_ALONG_RST = 15'd16384;
   localparam logic [14:0] SPEED_LIMIT_RST = 15'd32767;

   localparam logic [1:0] REG_DEADBAND = 2'd0;
   localparam logic [1:0] REG_GAIN_ACROSS = 2'd1;
   localparam logic [1:0] REG_GAIN_ALONG = 2'd2;
   localparam logic [1:0] REG_SPEED_LIMIT = 2'd3;

   typedef logic signed [VW-1:0] vec_type;

   typedef struct packed {
      logic [14:0] deadband_level;
      logic [14:0] rotation_gain_across;
      logic [14:0] rotation_gain_along;
      logic [14:0] speed_limit;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic ld_ra;
      logic ld_rl;
      logic rot_init;
      logic vec_init;
      logic cordic_step;
      logic cordic_vec;
      logic ld_px;
      logic ld_py;
      logic ld_mag;
      logic div_init;
      logic div_step;
      logic div_end;
      logic turn;
      logic out_load;
      logic [1:0] mod;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic idle;
      logic pre_zero;
   } status_type;

   function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
      logic [31:0] r;
      case (i)
         5'd0: r = 32'd536870912;
         5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;
         5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;
         5'd5: r = 32'd21354465;
         5'd6: r = 32'd10679838;
         5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;
         5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/sdmc_if.sv =====
// Request and response channel interfaces.
interface sdmc_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] strafe;
   logic signed [15:0] forward;
   logic signed [15:0] rotate;
   logic signed [15:0] heading;
   logic signed [15:0] enc_front_left;
   logic signed [15:0] enc_front_right;
   logic signed [15:0] enc_back_left;
   logic signed [15:0] enc_back_right;
   modport source (output valid, strafe, forward, rotate, heading, enc_front_left,
                   enc_front_right, enc_back_left, enc_back_right, input ready);
   modport sink (input valid, strafe, forward, rotate, heading, enc_front_left,
                 enc_front_right, enc_back_left, enc_back_right, output ready);
endinterface

interface sdmc_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] drive_front_left;
   logic signed [15:0] drive_front_right;
   logic signed [15:0] drive_back_left;
   logic signed [15:0] drive_back_right;
   logic signed [15:0] turn_front_left;
   logic signed [15:0] turn_front_right;
   logic signed [15:0] turn_back_left;
   logic signed [15:0] turn_back_right;
   logic no_command;
   modport source (output valid, drive_front_left, drive_front_right, drive_back_left,
                   drive_back_right, turn_front_left, turn_front_right, turn_back_left,
                   turn_back_right, no_command, input ready);
   modport sink (input valid, drive_front_left, drive_front_right, drive_back_left,
                 drive_back_right, turn_front_left, turn_front_right, turn_back_left,
                 turn_back_right, no_command, output ready);
endinterface

// ===== hw/rtl/sdmc_csr.sv =====
// APB-style configuration registers.
module sdmc_csr (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [3:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready,
   output sdmc_pkg::cfg_type cfg
);
   import sdmc_pkg::*;

   cfg_type cfg_ff;
   logic wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband_level <= DEADBAND_RST;
         cfg_ff.rotation_gain_across <= GAIN_ACROSS_RST;
         cfg_ff.rotation_gain_along <= GAIN_ALONG_RST;
         cfg_ff.speed_limit <= SPEED_LIMIT_RST;
      end else if (wr) begin
         unique case (paddr[3:2])
            REG_DEADBAND: cfg_ff.deadband_level <= pwdata[14:0];
            REG_GAIN_ACROSS: cfg_ff.rotation_gain_across <= pwdata[14:0];
            REG_GAIN_ALONG: cfg_ff.rotation_gain_along <= pwdata[14:0];
            REG_SPEED_LIMIT: cfg_ff.speed_limit <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_DEADBAND: prdata = {17'd0, cfg_ff.deadband_level};
         REG_GAIN_ACROSS: prdata = {17'd0, cfg_ff.rotation_gain_across};
         REG_GAIN_ALONG: prdata = {17'd0, cfg_ff.rotation_gain_along};
         REG_SPEED_LIMIT: prdata = {17'd0, cfg_ff.speed_limit};
         default: prdata = 32'd0;
      endcase
   end
endmodule

// ===== hw/rtl/sdmc_ctrl.sv =====
// Sequencing state machine of the commander.
module sdmc_ctrl #(
   parameter int CORDIC_STEPS = sdmc_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  sdmc_pkg::status_type status,
   output sdmc_pkg::cmd_type cmd
);
   import sdmc_pkg::*;

   localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(CORDIC_STEPS - 1);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_PRE_RA = 14'b00000000000010,
      S_PRE_RL = 14'b00000000000100,
      S_ROT    = 14'b00000000001000,
      S_ROT_X  = 14'b00000000010000,
      S_ROT_Y  = 14'b00000000100000,
      S_V_INIT = 14'b00000001000000,
      S_V_STEP = 14'b00000010000000,
      S_V_MAG  = 14'b00000100000000,
      S_D_INIT = 14'b00001000000000,
      S_D_STEP = 14'b00010000000000,
      S_D_END  = 14'b00100000000000,
      S_TURN   = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] mod_ff, mod_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      mod_in = mod_ff;
      step_in = step_ff;
      cmd = '0;
      cmd.mod = mod_ff;
      cmd.step = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PRE_RA;
            end
         end
         S_PRE_RA: begin
            mod_in = 2'd0;
            if (status.idle) begin
               state_in = S_TURN;
            end else begin
               cmd.ld_ra = 1'b1;
               state_in = S_PRE_RL;
            end
         end
         S_PRE_RL: begin
            cmd.ld_rl = 1'b1;
            cmd.rot_init = 1'b1;
            step_in = '0;
            state_in = status.pre_zero ? S_V_INIT : S_ROT;
         end
         S_ROT: begin
            cmd.cordic_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == CORDIC_LAST) state_in = S_ROT_X;
         end
         S_ROT_X: begin
            cmd.ld_px = 1'b1;
            state_in = S_ROT_Y;
         end
         S_ROT_Y: begin
            cmd.ld_py = 1'b1;
            state_in = S_V_INIT;
         end
         S_V_INIT: begin
            cmd.vec_init = 1'b1;
            step_in = '0;
            state_in = S_V_STEP;
         end
         S_V_STEP: begin
            cmd.cordic_step = 1'b1;
            cmd.cordic_vec = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == CORDIC_LAST) state_in = S_V_MAG;
         end
         S_V_MAG: begin
            cmd.ld_mag = 1'b1;
            mod_in = mod_ff + 1'b1;
            state_in = (mod_ff == 2'd3) ? S_D_INIT : S_V_INIT;
         end
         S_D_INIT: begin
            cmd.div_init = 1'b1;
            step_in = '0;
            state_in = S_D_STEP;
         end
         S_D_STEP: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) state_in = S_D_END;
         end
         S_D_END: begin
            cmd.div_end = 1'b1;
            mod_in = mod_ff + 1'b1;
            state_in = (mod_ff == 2'd3) ? S_TURN : S_D_INIT;
         end
         S_TURN: begin
            cmd.turn = 1'b1;
            mod_in = mod_ff + 1'b1;
            if (mod_ff == 2'd3) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mod_ff <= 2'd0;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mod_ff <= mod_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== hw/rtl/sdmc_dp.sv =====
// Datapath: deadband, CORDIC, shared multiplier, divider and steering fold.
module sdmc_dp (
   input  logic clock,
   input  logic reset,
   input  sdmc_pkg::cfg_type cfg,
   input  sdmc_pkg::cmd_type cmd,
   output sdmc_pkg::status_type status,
   input  logic signed [15:0] strafe,
   input  logic signed [15:0] forward,
   input  logic signed [15:0] rotate,
   input  logic signed [15:0] heading,
   input  logic signed [15:0] enc_front_left,
   input  logic signed [15:0] enc_front_right,
   input  logic signed [15:0] enc_back_left,
   input  logic signed [15:0] enc_back_right,
   output logic signed [15:0] drive_front_left,
   output logic signed [15:0] drive_front_right,
   output logic signed [15:0] drive_back_left,
   output logic signed [15:0] drive_back_right,
   output logic signed [15:0] turn_front_left,
   output logic signed [15:0] turn_front_right,
   output logic signed [15:0] turn_back_left,
   output logic signed [15:0] turn_back_right,
   output logic no_command
);
   import sdmc_pkg::*;

   localparam logic signed [32:0] Z_QUARTER = 33'sh040000000;
   localparam logic signed [32:0] Z_HALF = 33'sh080000000;
   localparam logic [VW-1:0] MAX_FLOOR = VW'(36'd33554432);

   logic signed [15:0] sx_ff, fy_ff, rt_ff;
   logic [15:0] hd_ff;
   logic [15:0] enc_ff [4];
   vec_type ra_ff, rl_ff, px_ff, py_ff, x_ff, y_ff;
   logic signed [32:0] z_ff;
   logic zero_ff;
   logic [VW-1:0] mag_ff [4];
   logic [VW-1:0] maxm_ff;
   logic [15:0] held_ff [4];
   logic flip_ff [4];
   logic [DVW-1:0] rem_ff, dvs_ff;
   logic [QW-1:0] q_ff;
   logic signed [15:0] drive_ff [4];
   logic signed [15:0] turn_ff [4];
   logic signed [15:0] out_drive_ff [4];
   logic signed [15:0] out_turn_ff [4];
   logic out_nc_ff;

   vec_type mul_a;
   logic signed [31:0] mul_b;
   logic signed [PW-1:0] prod;
   logic [16:0] rabs;
   vec_type dx, dy, vx, vy, p_sc;
   logic [31:0] atan_v;
   logic signed [32:0] z_pre;
   logic [15:0] hneg;
   logic [31:0] ang;
   logic [15:0] tgt, dtg, dth;
   logic signed [16:0] dfold;
   logic [14:0] da;
   logic [VW-1:0] mag_v;
   logic [15:0] q_ext;

   function automatic logic signed [15:0] dband(input logic signed [15:0] v,
                                                input logic [14:0] lvl);
      logic signed [16:0] w;
      logic [16:0] m;
      w = 17'(v);
      m = (w < 0) ? 17'(-w) : 17'(w);
      return (m <= {2'b00, lvl}) ? 16'sd0 : v;
   endfunction

   assign rabs = (rt_ff < 0) ? 17'(-17'(rt_ff)) : 17'(rt_ff);
   assign status.pre_zero = (sx_ff == 16'sd0) && (fy_ff == 16'sd0);
   assign status.idle = status.pre_zero && (rabs < ROT_IDLE_LIMIT);

   assign dx = y_ff >>> cmd.step;
   assign dy = x_ff >>> cmd.step;
   assign atan_v = atan_entry(cmd.step);
   assign hneg = 16'd0 - hd_ff;
   assign z_pre = 33'(signed'({hneg, 16'h0000}));

   always_comb begin
      vx = px_ff + ((cmd.mod[1] == 1'b0) ? ra_ff : -ra_ff);
      vy = py_ff + ((cmd.mod[0] == 1'b0) ? -rl_ff : rl_ff);
   end

   // signed wrap of held target minus encoder, folded into a half turn
   always_comb begin
      dth = held_ff[cmd.mod] - enc_ff[cmd.mod];
      dfold = 17'(signed'(dth));
      if (dfold > QUARTER_TURN) dfold = dfold - HALF_TURN;
      else if (dfold < -QUARTER_TURN) dfold = dfold + HALF_TURN;
      da = (dfold < 0) ? 15'(-dfold) : 15'(dfold);
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.ld_ra) begin
         mul_a = VW'(rt_ff);
         mul_b = {17'd0, cfg.rotation_gain_across};
      end else if (cmd.ld_rl) begin
         mul_a = VW'(rt_ff);
         mul_b = {17'd0, cfg.rotation_gain_along};
      end else if (cmd.ld_px || cmd.ld_mag) begin
         mul_a = x_ff;
         mul_b = INV_GAIN;
      end else if (cmd.ld_py) begin
         mul_a = y_ff;
         mul_b = INV_GAIN;
      end else if (cmd.div_init) begin
         mul_a = signed'(mag_ff[cmd.mod]);
         mul_b = {17'd0, cfg.speed_limit};
      end else if (cmd.turn) begin
         mul_a = VW'(signed'({1'b0, da}));
         mul_b = {17'd0, cfg.speed_limit};
      end
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      p_sc = VW'(prod >>> 30);
      mag_v = (zero_ff || p_sc < 0) ? '0 : VW'(p_sc);
      ang = zero_ff ? 32'd0 : z_ff[31:0];
      tgt = ang[31:16] + {15'd0, ang[15]};
      dtg = tgt - enc_ff[cmd.mod];
      q_ext = {1'b0, q_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sx_ff <= dband(strafe, cfg.deadband_level);
         fy_ff <= dband(forward, cfg.deadband_level);
         rt_ff <= dband(rotate, cfg.deadband_level);
         hd_ff <= heading;
         enc_ff[0] <= enc_front_left;
         enc_ff[1] <= enc_front_right;
         enc_ff[2] <= enc_back_left;
         enc_ff[3] <= enc_back_right;
         px_ff <= '0;
         py_ff <= '0;
         maxm_ff <= MAX_FLOOR;
         for (int i = 0; i < 4; i++) drive_ff[i] <= 16'sd0;
      end
      if (cmd.ld_ra) ra_ff <= VW'(prod >>> 5);
      if (cmd.ld_rl) rl_ff <= VW'(prod >>> 5);
      if (cmd.rot_init) begin
         if (z_pre > Z_QUARTER) begin
            z_ff <= z_pre - Z_HALF;
            x_ff <= -(VW'(sx_ff) <<< 10);
            y_ff <= -(VW'(fy_ff) <<< 10);
         end else if (z_pre < -Z_QUARTER) begin
            z_ff <= z_pre + Z_HALF;
            x_ff <= -(VW'(sx_ff) <<< 10);
            y_ff <= -(VW'(fy_ff) <<< 10);
         end else begin
            z_ff <= z_pre;
            x_ff <= VW'(sx_ff) <<< 10;
            y_ff <= VW'(fy_ff) <<< 10;
         end
      end
      if (cmd.vec_init) begin
         zero_ff <= (vx == 0) && (vy == 0);
         if (vy < 0) begin
            x_ff <= -vy;
            y_ff <= -vx;
            z_ff <= Z_HALF;
         end else begin
            x_ff <= vy;
            y_ff <= vx;
            z_ff <= '0;
         end
      end
      if (cmd.cordic_step) begin
         if (cmd.cordic_vec ? (y_ff >= 0) : (z_ff < 0)) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
         end
         if (cmd.cordic_vec ? (y_ff >= 0) : (z_ff < 0)) z_ff <= z_ff + 33'(atan_v);
         else z_ff <= z_ff - 33'(atan_v);
      end
      if (cmd.ld_px) px_ff <= p_sc;
      if (cmd.ld_py) py_ff <= p_sc;
      if (cmd.ld_mag) begin
         mag_ff[cmd.mod] <= mag_v;
         if (mag_v > maxm_ff) maxm_ff <= mag_v;
         flip_ff[cmd.mod] <= (signed'(dtg) > 16'sd16384) || (signed'(dtg) < -16'sd16384);
      end
      if (cmd.div_init) begin
         rem_ff <= prod[DVW-1:0];
         dvs_ff <= {maxm_ff[DVW-15:0], 14'd0};
         q_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_ff >= dvs_ff) begin
            rem_ff <= rem_ff - dvs_ff;
            q_ff <= {q_ff[QW-2:0], 1'b1};
         end else begin
            q_ff <= {q_ff[QW-2:0], 1'b0};
         end
         dvs_ff <= dvs_ff >> 1;
      end
      if (cmd.div_end) drive_ff[cmd.mod] <= flip_ff[cmd.mod] ? -signed'(q_ext) : signed'(q_ext);
      if (cmd.turn) begin
         turn_ff[cmd.mod] <= (dfold < 0) ? -signed'({1'b0, prod[28:14]})
                                         : signed'({1'b0, prod[28:14]});
      end
      if (cmd.out_load) begin
         for (int i = 0; i < 4; i++) begin
            out_drive_ff[i] <= drive_ff[i];
            out_turn_ff[i] <= turn_ff[i];
         end
         out_nc_ff <= status.idle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) held_ff[i] <= 16'd0;
      end else if (cmd.ld_mag) begin
         held_ff[cmd.mod] <= tgt;
      end
   end

   assign drive_front_left = out_drive_ff[0];
   assign drive_front_right = out_drive_ff[1];
   assign drive_back_left = out_drive_ff[2];
   assign drive_back_right = out_drive_ff[3];
   assign turn_front_left = out_turn_ff[0];
   assign turn_front_right = out_turn_ff[1];
   assign turn_back_left = out_turn_ff[2];
   assign turn_back_right = out_turn_ff[3];
   assign no_command = out_nc_ff;
endmodule

// ===== hw/rtl/swerve_drive_module_commander.sv =====
// Top level of the four-module swerve drive commander.
// One command beat is taken at a time and answered with one response beat.
// From its accept cycle until the block is ready again, a beat with idle sticks
// goes through accept, decision, four steering steps and output load. Other
// beats spend their time in the single shared CORDIC stage and the divider.
// The CORDIC stage makes one rotation pass, which is skipped when there is no
// translation. It then makes one vectoring pass per module. The bit-serial
// divider then scales the drive magnitude of each module.
// The output load stalls while the previous response beat is still
// unaccepted. The next command beat is accepted while a response beat waits.
module swerve_drive_module_commander #(
   parameter int CORDIC_STEPS = sdmc_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   sdmc_req_if.sink req_chan,
   sdmc_rsp_if.source rsp_chan,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [3:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import sdmc_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   status_type status;

   sdmc_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   sdmc_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .status(status), .cmd(cmd)
   );

   sdmc_dp u_dp (
      .clock(clock), .reset(reset), .cfg(cfg), .cmd(cmd), .status(status),
      .strafe(req_chan.strafe), .forward(req_chan.forward), .rotate(req_chan.rotate),
      .heading(req_chan.heading),
      .enc_front_left(req_chan.enc_front_left), .enc_front_right(req_chan.enc_front_right),
      .enc_back_left(req_chan.enc_back_left), .enc_back_right(req_chan.enc_back_right),
      .drive_front_left(rsp_chan.drive_front_left),
      .drive_front_right(rsp_chan.drive_front_right),
      .drive_back_left(rsp_chan.drive_back_left),
      .drive_back_right(rsp_chan.drive_back_right),
      .turn_front_left(rsp_chan.turn_front_left),
      .turn_front_right(rsp_chan.turn_front_right),
      .turn_back_left(rsp_chan.turn_back_left),
      .turn_back_right(rsp_chan.turn_back_right),
      .no_command(rsp_chan.no_command)
   );
endmodule

// ===== hw/rtl/sdmc_checker.sv =====
// Port-level checker for the commander and its bind.
`include "swerve_drive_module_commander_defines.svh"
module sdmc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [15:0] drive_front_left,
   input logic signed [15:0] drive_back_right,
   input logic signed [15:0] turn_front_left,
   input logic signed [15:0] turn_back_right,
   input logic no_command
);
   `SDMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SDMC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `SDMC_ASSERT_HOLDS(a_idle_no_drive, clock, reset, rsp_valid && no_command,
      drive_front_left == 16'sd0 && drive_back_right == 16'sd0)
   `SDMC_ASSERT_HOLDS(a_turn_range, clock, reset, rsp_valid,
      turn_front_left != -16'sd32768 && turn_back_right != -16'sd32768)
endmodule

bind swerve_drive_module_commander sdmc_checker u_sdmc_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_chan.valid), .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .drive_front_left(rsp_chan.drive_front_left),
   .drive_back_right(rsp_chan.drive_back_right),
   .turn_front_left(rsp_chan.turn_front_left),
   .turn_back_right(rsp_chan.turn_back_right),
   .no_command(rsp_chan.no_command)
);
